// ----- rtl/rfs_pkg.sv -----
// shared constants, types and codes of the rainflow three-point stack unit
package rfs_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ALU_W       = SAMPLE_BITS + 1;

  typedef logic signed [SAMPLE_BITS-1:0] level_t;
  typedef logic [SAMPLE_BITS-1:0]        range_t;
  typedef logic signed [ALU_W-1:0]       alu_op_t;

  typedef enum logic [1:0] {
    KIND_FULL = 2'd0,
    KIND_HALF = 2'd1,
    KIND_OVF  = 2'd2,
    KIND_END  = 2'd3
  } kind_t;

  typedef struct packed {
    logic   gt;
    logic   eq;
    range_t absd;
  } alu_res_t;

endpackage

// ----- rtl/rfs_alu.sv -----
// shared subtract and compare unit: order, equality and absolute difference
module rfs_alu
  import rfs_pkg::*;
(
  input  alu_op_t  op_a,
  input  alu_op_t  op_b,
  output alu_res_t res
);

  logic signed [ALU_W:0] diff;
  logic signed [ALU_W:0] mag;
  logic                  neg;
  logic                  zero;

  assign diff = {op_a[ALU_W-1], op_a} - {op_b[ALU_W-1], op_b};
  assign neg  = diff[ALU_W];
  assign zero = (diff == '0);
  assign mag  = neg ? -diff : diff;

  assign res.gt   = !neg && !zero;
  assign res.eq   = zero;
  assign res.absd = mag[SAMPLE_BITS-1:0];

endmodule

// ----- rtl/rainflow_three_point_stack_unit.sv -----
// top level of the rainflow three-point stack unit
// a new sample is taken only in S_IDLE; in_stall stays high until the sequencer is back
// a turning point passes S_PUSH; each range check runs S_RD1, S_RD0, S_CMP and S_DEC
// an end item then flushes the stack as half cycles via S_FL0, S_FLA, S_FLB before S_END
// results may wait in the output register past acceptance; a full output holds the sequencer
// synchronous active-low reset empties the stack and clears the series state at once
module rainflow_three_point_stack_unit
  import rfs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_end_of_series,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_level_high,
  output logic [SAMPLE_BITS-1:0] out_level_low,
  output logic [1:0]             out_result_kind,
  output logic                   out_last_in_run
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLS,
    S_EOS,
    S_PUSH,
    S_RD1,
    S_RD0,
    S_CMP,
    S_DEC,
    S_FL0,
    S_FLA,
    S_FLB,
    S_END,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  level_t mem [STACK_DEPTH];
  level_t rd_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  level_t s_r, s_nxt;
  logic   eos_r, eos_nxt;
  logic   first_r, first_nxt;
  logic   ovf_r, ovf_nxt;
  logic   push2_r, push2_nxt;
  level_t push_val_r, push_val_nxt;
  level_t top_r, top_nxt;
  level_t x1_r, x1_nxt;
  level_t a_r, a_nxt;
  range_t d1_r, d1_nxt;
  range_t d0_r, d0_nxt;
  logic   gt_r, gt_nxt;
  level_t last_ext_r, last_ext_nxt;
  level_t pend_r, pend_nxt;
  logic   pend_v_r, pend_v_nxt;
  logic   rising_r, rising_nxt;
  logic   seen_r, seen_nxt;

  logic   hold_v_r, hold_v_nxt;
  level_t hold_hi_r, hold_hi_nxt;
  level_t hold_lo_r, hold_lo_nxt;
  kind_t  hold_kind_r, hold_kind_nxt;
  logic   out_v_r, out_v_nxt;
  level_t out_hi_r, out_hi_nxt;
  level_t out_lo_r, out_lo_nxt;
  kind_t  out_kind_r, out_kind_nxt;
  logic   out_last_r, out_last_nxt;

  alu_op_t  alu_a;
  alu_op_t  alu_b;
  alu_res_t alu;

  logic   emit_req;
  logic   emit_fire;
  level_t emit_hi;
  level_t emit_lo;
  kind_t  emit_kind;
  logic   out_free;
  logic   can_emit;
  logic   move_fin;
  state_t ret_state;

  logic [CNT_W-1:0] cnt_m2;
  logic [CNT_W-1:0] cnt_m3;
  logic [CNT_W-1:0] idx_p1;
  logic [CNT_W-1:0] idx_p2;

  rfs_alu u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .res  (alu)
  );

  assign out_free  = !out_v_r || !out_stall;
  assign can_emit  = !hold_v_r || out_free;
  assign emit_fire = emit_req && can_emit;
  assign move_fin  = (state_r == S_FIN) && hold_v_r && out_free;
  assign ret_state = push2_r ? S_FL0 : S_EOS;

  assign cnt_m2 = cnt_r - CNT_W'(2);
  assign cnt_m3 = cnt_r - CNT_W'(3);
  assign idx_p1 = idx_r + CNT_W'(1);
  assign idx_p2 = idx_r + CNT_W'(2);

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_v_r;
  assign out_level_high  = out_hi_r;
  assign out_level_low   = out_lo_r;
  assign out_result_kind = out_kind_r;
  assign out_last_in_run = out_last_r;

  // shared unit operand select
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_r)
      S_CLS: begin
        alu_a = {s_r[SAMPLE_BITS-1], s_r};
        if (pend_v_r) begin
          alu_b = {pend_r[SAMPLE_BITS-1], pend_r};
        end else begin
          alu_b = {last_ext_r[SAMPLE_BITS-1], last_ext_r};
        end
      end
      S_RD0: begin
        alu_a = {top_r[SAMPLE_BITS-1], top_r};
        alu_b = {rd_r[SAMPLE_BITS-1], rd_r};
      end
      S_CMP: begin
        alu_a = {x1_r[SAMPLE_BITS-1], x1_r};
        alu_b = {rd_r[SAMPLE_BITS-1], rd_r};
      end
      S_DEC: begin
        alu_a = {1'b0, d1_r};
        alu_b = {1'b0, d0_r};
      end
      S_FLB: begin
        alu_a = {a_r[SAMPLE_BITS-1], a_r};
        alu_b = {rd_r[SAMPLE_BITS-1], rd_r};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    s_nxt         = s_r;
    eos_nxt       = eos_r;
    first_nxt     = first_r;
    ovf_nxt       = ovf_r;
    push2_nxt     = push2_r;
    push_val_nxt  = push_val_r;
    top_nxt       = top_r;
    x1_nxt        = x1_r;
    a_nxt         = a_r;
    d1_nxt        = d1_r;
    d0_nxt        = d0_r;
    gt_nxt        = gt_r;
    last_ext_nxt  = last_ext_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    rising_nxt    = rising_r;
    seen_nxt      = seen_r;
    rd_addr       = cnt_m2[ADDR_W-1:0];
    wr_en         = 1'b0;
    emit_req      = 1'b0;
    emit_hi       = '0;
    emit_lo       = '0;
    emit_kind     = KIND_END;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          s_nxt     = level_t'(in_sample);
          eos_nxt   = in_end_of_series;
          first_nxt = !seen_r;
          ovf_nxt   = 1'b0;
          push2_nxt = 1'b0;
          state_nxt = S_CLS;
        end
      end
      S_CLS: begin
        priority if (!seen_r) begin
          push_val_nxt = s_r;
          last_ext_nxt = s_r;
          seen_nxt     = 1'b1;
          pend_v_nxt   = 1'b0;
          rising_nxt   = 1'b0;
          state_nxt    = S_PUSH;
        end else if (!pend_v_r) begin
          if (!alu.eq) begin
            pend_nxt   = s_r;
            rising_nxt = alu.gt;
            pend_v_nxt = 1'b1;
          end
          state_nxt = S_EOS;
        end else if (alu.eq) begin
          state_nxt = S_EOS;
        end else if (rising_r ? alu.gt : !alu.gt) begin
          pend_nxt  = s_r;
          state_nxt = S_EOS;
        end else begin
          push_val_nxt = pend_r;
          last_ext_nxt = pend_r;
          pend_nxt     = s_r;
          rising_nxt   = !rising_r;
          state_nxt    = S_PUSH;
        end
      end
      S_EOS: begin
        priority if (!eos_r) begin
          state_nxt = S_FIN;
        end else if (pend_v_r) begin
          push_val_nxt = pend_r;
          push2_nxt    = 1'b1;
          state_nxt    = S_PUSH;
        end else if (!first_r) begin
          push_val_nxt = s_r;
          push2_nxt    = 1'b1;
          state_nxt    = S_PUSH;
        end else begin
          state_nxt = S_FL0;
        end
      end
      S_PUSH: begin
        if (cnt_r == CNT_W'(STACK_DEPTH)) begin
          if (!ovf_r) begin
            emit_req  = 1'b1;
            emit_hi   = push_val_r;
            emit_lo   = push_val_r;
            emit_kind = KIND_OVF;
            if (can_emit) begin
              ovf_nxt   = 1'b1;
              state_nxt = ret_state;
            end
          end else begin
            state_nxt = ret_state;
          end
        end else begin
          wr_en     = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
          top_nxt   = push_val_r;
          state_nxt = (cnt_r >= CNT_W'(2)) ? S_RD1 : ret_state;
        end
      end
      S_RD1: begin
        rd_addr   = cnt_m2[ADDR_W-1:0];
        state_nxt = S_RD0;
      end
      S_RD0: begin
        rd_addr   = cnt_m3[ADDR_W-1:0];
        x1_nxt    = rd_r;
        d1_nxt    = alu.absd;
        gt_nxt    = alu.gt;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        a_nxt     = rd_r;
        d0_nxt    = alu.absd;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (!alu.gt) begin
          emit_req  = 1'b1;
          emit_hi   = gt_r ? top_r : x1_r;
          emit_lo   = gt_r ? x1_r : top_r;
          emit_kind = KIND_FULL;
          if (can_emit) begin
            cnt_nxt   = cnt_m2;
            top_nxt   = a_r;
            state_nxt = (cnt_r >= CNT_W'(5)) ? S_RD1 : ret_state;
          end
        end else begin
          state_nxt = ret_state;
        end
      end
      S_FL0: begin
        idx_nxt = '0;
        rd_addr = '0;
        if (cnt_r < CNT_W'(2)) begin
          state_nxt = S_END;
        end else begin
          state_nxt = S_FLA;
        end
      end
      S_FLA: begin
        a_nxt     = rd_r;
        rd_addr   = idx_p1[ADDR_W-1:0];
        state_nxt = S_FLB;
      end
      S_FLB: begin
        rd_addr   = idx_p1[ADDR_W-1:0];
        emit_req  = 1'b1;
        emit_hi   = alu.gt ? a_r : rd_r;
        emit_lo   = alu.gt ? rd_r : a_r;
        emit_kind = KIND_HALF;
        if (can_emit) begin
          rd_addr = idx_p2[ADDR_W-1:0];
          a_nxt   = rd_r;
          idx_nxt = idx_p1;
          if (idx_p2 >= cnt_r) begin
            state_nxt = S_END;
          end
        end
      end
      S_END: begin
        emit_req  = 1'b1;
        emit_kind = KIND_END;
        if (can_emit) begin
          cnt_nxt      = '0;
          last_ext_nxt = '0;
          pend_nxt     = '0;
          pend_v_nxt   = 1'b0;
          rising_nxt   = 1'b0;
          seen_nxt     = 1'b0;
          state_nxt    = S_FIN;
        end
      end
      S_FIN: begin
        if (!hold_v_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result holding stage and output register
  always_comb begin
    hold_v_nxt    = hold_v_r;
    hold_hi_nxt   = hold_hi_r;
    hold_lo_nxt   = hold_lo_r;
    hold_kind_nxt = hold_kind_r;
    out_v_nxt     = out_free ? 1'b0 : out_v_r;
    out_hi_nxt    = out_hi_r;
    out_lo_nxt    = out_lo_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    if (emit_fire) begin
      if (hold_v_r) begin
        out_v_nxt    = 1'b1;
        out_hi_nxt   = hold_hi_r;
        out_lo_nxt   = hold_lo_r;
        out_kind_nxt = hold_kind_r;
        out_last_nxt = 1'b0;
      end
      hold_v_nxt    = 1'b1;
      hold_hi_nxt   = emit_hi;
      hold_lo_nxt   = emit_lo;
      hold_kind_nxt = emit_kind;
    end else if (move_fin) begin
      out_v_nxt    = 1'b1;
      out_hi_nxt   = hold_hi_r;
      out_lo_nxt   = hold_lo_r;
      out_kind_nxt = hold_kind_r;
      out_last_nxt = 1'b1;
      hold_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[ADDR_W-1:0]] <= push_val_r;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      pend_v_r   <= 1'b0;
      rising_r   <= 1'b0;
      seen_r     <= 1'b0;
      last_ext_r <= '0;
      pend_r     <= '0;
      hold_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      pend_v_r   <= pend_v_nxt;
      rising_r   <= rising_nxt;
      seen_r     <= seen_nxt;
      last_ext_r <= last_ext_nxt;
      pend_r     <= pend_nxt;
      hold_v_r   <= hold_v_nxt;
      out_v_r    <= out_v_nxt;
    end
    idx_r       <= idx_nxt;
    s_r         <= s_nxt;
    eos_r       <= eos_nxt;
    first_r     <= first_nxt;
    ovf_r       <= ovf_nxt;
    push2_r     <= push2_nxt;
    push_val_r  <= push_val_nxt;
    top_r       <= top_nxt;
    x1_r        <= x1_nxt;
    a_r         <= a_nxt;
    d1_r        <= d1_nxt;
    d0_r        <= d0_nxt;
    gt_r        <= gt_nxt;
    hold_hi_r   <= hold_hi_nxt;
    hold_lo_r   <= hold_lo_nxt;
    hold_kind_r <= hold_kind_nxt;
    out_hi_r    <= out_hi_nxt;
    out_lo_r    <= out_lo_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !hold_v_r)
    else $error("result left in holding stage between transactions");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire && hold_v_r |-> out_free)
    else $error("held result overwritten");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_END && emit_fire |=> cnt_r == '0 && !seen_r && !pend_v_r)
    else $error("series state not cleared after end marker");
`endif

endmodule
